[hw/rtl/pvc_pkg.sv]
// pvc_pkg: shared widths, verdict codes and item types for the permutation checker.
// No dependencies; compile first.
package pvc_pkg;

	localparam int JOB_W        = 16;
	localparam int CNT_W        = 11;
	localparam int CMP_W        = JOB_W + 1;
	localparam int VERD_W       = 3;
	localparam int MAX_JOBS_DEF = 1024;

	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

	localparam logic [VERD_W-1:0] V_OK      = 3'd0;
	localparam logic [VERD_W-1:0] V_BELOW   = 3'd1;
	localparam logic [VERD_W-1:0] V_ABOVE   = 3'd2;
	localparam logic [VERD_W-1:0] V_REPEAT  = 3'd3;
	localparam logic [VERD_W-1:0] V_MISSING = 3'd4;

	typedef struct packed {
		logic [JOB_W-1:0] job_number;
		logic             has_job;
		logic             last_item;
	} in_item_t;

	typedef struct packed {
		logic [VERD_W-1:0] verdict;
		logic [JOB_W-1:0]  offending_job;
	} out_item_t;

endpackage

[hw/rtl/permutation_validity_check.sv]
// permutation_validity_check: top level. Uses pvc_pkg and pvc_ram (seen flags).
// Non-last item with a job in range and no earlier error: flag read at acceptance,
// flag update in the busy ST_LOOK state after it; any other non-last item keeps the block idle.
// Last item: sweep over all MAX_JOBS flags (after ST_LOOK with a job in range), then
// ST_REPORT; busy until done rises; done is high 1 cycle.
// Reset: busy for a clearing pass over all flags; the job count cfg_q resets to 1024.
module permutation_validity_check #(
	parameter int MAX_JOBS = pvc_pkg::MAX_JOBS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  pvc_pkg::in_item_t        item,
	input  logic                     cfg_we,
	input  logic [pvc_pkg::CNT_W-1:0] cfg_data,
	output logic                     done,
	output pvc_pkg::out_item_t       result
);
	import pvc_pkg::*;

	localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_JOBS - 1);
	localparam logic [CMP_W-1:0] MAX_C     = CMP_W'(MAX_JOBS);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOK   = 2'd1;
	localparam logic [1:0] ST_SWEEP  = 2'd2;
	localparam logic [1:0] ST_REPORT = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cfg_q;
	logic [VERD_W-1:0] err_q;
	logic [JOB_W-1:0]  errjob_q;
	logic              report_q;
	logic              issue_q;
	logic [AW-1:0]     rd_addr_q;
	logic              vld_s1;
	logic              done_q;

	logic [JOB_W-1:0]  look_job_q;
	logic [AW-1:0]     look_addr_q;
	logic              last_q;
	logic [CMP_W-1:0]  cnt_q;
	logic [AW-1:0]     addr_s1;
	out_item_t         result_q;

	logic [CMP_W-1:0]  eff;
	logic              accept;
	logic [JOB_W-1:0]  jm1;
	logic              chk;
	logic              is_below;
	logic              is_above;
	logic              sw_miss;
	logic              sw_end;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic              ram_rdata;

	assign eff      = (CMP_W'(cfg_q) > MAX_C) ? MAX_C : CMP_W'(cfg_q);
	assign accept   = start && (state_q == ST_IDLE);
	assign jm1      = item.job_number - 16'd1;
	assign chk      = item.has_job && (err_q == V_OK);
	assign is_below = (item.job_number == '0);
	assign is_above = (CMP_W'(item.job_number) > eff);

	// sweep: flag at addr_s1 is on ram_rdata this cycle; clear it behind the read
	assign sw_miss = vld_s1 && report_q && (err_q == V_OK) &&
	                 (CMP_W'(addr_s1) < cnt_q) && !ram_rdata;
	assign sw_end  = vld_s1 && (addr_s1 == LAST_ADDR);

	assign ram_raddr = (state_q == ST_SWEEP) ? rd_addr_q : jm1[AW-1:0];
	assign ram_we    = ((state_q == ST_LOOK) && !ram_rdata) ||
	                   ((state_q == ST_SWEEP) && vld_s1);
	assign ram_waddr = (state_q == ST_LOOK) ? look_addr_q : addr_s1;
	assign ram_wdata = (state_q == ST_LOOK);

	pvc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_JOBS),
		.AW    (AW)
	) u_seen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			cfg_q     <= CNT_RESET;
			err_q     <= V_OK;
			errjob_q  <= '0;
			report_q  <= 1'b0;
			issue_q   <= 1'b1;
			rd_addr_q <= '0;
			vld_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (chk && is_below) begin
							err_q    <= V_BELOW;
							errjob_q <= item.job_number;
						end else if (chk && is_above) begin
							err_q    <= V_ABOVE;
							errjob_q <= item.job_number;
						end
						if (chk && !is_below && !is_above) begin
							state_q <= ST_LOOK;
						end else if (item.last_item) begin
							state_q   <= ST_SWEEP;
							report_q  <= 1'b1;
							issue_q   <= 1'b1;
							rd_addr_q <= '0;
							vld_s1    <= 1'b0;
						end
					end
				end
				ST_LOOK: begin
					if (ram_rdata) begin
						err_q    <= V_REPEAT;
						errjob_q <= look_job_q;
					end
					if (last_q) begin
						state_q   <= ST_SWEEP;
						report_q  <= 1'b1;
						issue_q   <= 1'b1;
						rd_addr_q <= '0;
						vld_s1    <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					vld_s1 <= issue_q;
					if (issue_q) begin
						if (rd_addr_q == LAST_ADDR) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + 1'b1;
						end
					end
					if (sw_miss) begin
						err_q    <= V_MISSING;
						errjob_q <= JOB_W'(addr_s1) + 16'd1;
					end
					if (sw_end) begin
						state_q <= report_q ? ST_REPORT : ST_IDLE;
					end
				end
				ST_REPORT: begin
					done_q   <= 1'b1;
					err_q    <= V_OK;
					errjob_q <= '0;
					report_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			look_job_q  <= item.job_number;
			look_addr_q <= jm1[AW-1:0];
			last_q      <= item.last_item;
			cnt_q       <= eff;
		end
		addr_s1 <= rd_addr_q;
		if (state_q == ST_REPORT) begin
			result_q.verdict       <= err_q;
			result_q.offending_job <= (err_q == V_OK) ? '0 : errjob_q;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[hw/rtl/pvc_ram.sv]
// pvc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pvc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
